@@ src/exp3_bandit_arm_selector_assert.svh @@
// ---------------------------------------------------------------------------
// Exp3 arm selector assertion macros
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef EXP3_BANDIT_ARM_SELECTOR_ASSERT_SVH
`define EXP3_BANDIT_ARM_SELECTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define EXP3_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("exp3 assertion failed");
// next-cycle implication, disabled during reset
`define EXP3_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("exp3 assertion failed");
`else
`define EXP3_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define EXP3_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ src/exp3_pkg.sv @@
// ---------------------------------------------------------------------------
// Exp3 arm selector package
// Shared sizes, datapath operation codes, command and status types.
// ---------------------------------------------------------------------------
`default_nettype none
package exp3_pkg;

  localparam int NUM_ARMS = 8;
  localparam int ARM_W    = $clog2(NUM_ARMS);
  localparam int CNT_W    = $clog2(NUM_ARMS + 1);

  localparam logic [16:0] Q_ONE = 17'd65536;
  localparam logic [16:0] LOG2E = 17'd94548;

  // serial divider sizes
  localparam int DIV_NW  = 40;
  localparam int DIV_DW  = 32;
  localparam int DIV_CW  = $clog2(DIV_NW);

  // configuration register indexes
  localparam logic [1:0] CFG_ETA    = 2'd0;
  localparam logic [1:0] CFG_GAMMA  = 2'd1;
  localparam logic [1:0] CFG_LAMBDA = 2'd2;

  // datapath operations
  localparam logic [4:0] OP_NONE   = 5'd0;
  localparam logic [4:0] OP_LOAD   = 5'd1;
  localparam logic [4:0] OP_MULX   = 5'd2;
  localparam logic [4:0] OP_MAX    = 5'd3;
  localparam logic [4:0] OP_DIFF   = 5'd4;
  localparam logic [4:0] OP_LOG    = 5'd5;
  localparam logic [4:0] OP_INTERP = 5'd6;
  localparam logic [4:0] OP_WACC   = 5'd7;
  localparam logic [4:0] OP_SHARE  = 5'd8;
  localparam logic [4:0] OP_SHGET  = 5'd9;
  localparam logic [4:0] OP_PDIV   = 5'd10;
  localparam logic [4:0] OP_PGET   = 5'd11;
  localparam logic [4:0] OP_CUM    = 5'd12;
  localparam logic [4:0] OP_SELFIX = 5'd13;
  localparam logic [4:0] OP_SELOUT = 5'd14;
  localparam logic [4:0] OP_UPREP  = 5'd15;
  localparam logic [4:0] OP_QGET   = 5'd16;
  localparam logic [4:0] OP_GMUL   = 5'd17;
  localparam logic [4:0] OP_GADD   = 5'd18;
  localparam logic [4:0] OP_ASP    = 5'd19;
  localparam logic [4:0] OP_TOT    = 5'd20;
  localparam logic [4:0] OP_MGET   = 5'd21;
  localparam logic [4:0] OP_UOUT   = 5'd22;

  // arm index steps
  localparam logic [1:0] IDX_KEEP = 2'd0;
  localparam logic [1:0] IDX_INC  = 2'd1;
  localparam logic [1:0] IDX_CLR  = 2'd2;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] idx_step;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic div_done;
    logic count_zero;
    logic allowed_cur;
    logic prob_zero;
    logic tau_zero;
    logic tot_zero;
    logic out_free;
  } sts_t;

  // 2^(-j/16) in Q16
  function automatic logic [16:0] pow2_tab(input logic [4:0] j);
    logic [16:0] v;
    unique case (j)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ src/exp3_div.sv @@
// ---------------------------------------------------------------------------
// Exp3 serial divider
// Unsigned restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module exp3_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [exp3_pkg::DIV_NW-1:0] num,
  input  wire logic [exp3_pkg::DIV_DW-1:0] den,
  output logic                             busy,
  output logic                             done,
  output logic [exp3_pkg::DIV_NW-1:0]      quo
);

  logic [exp3_pkg::DIV_DW-1:0] rem_r;
  logic [exp3_pkg::DIV_DW-1:0] den_r;
  logic [exp3_pkg::DIV_NW-1:0] quo_r;
  logic [exp3_pkg::DIV_CW-1:0] cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [exp3_pkg::DIV_DW:0]   shift;
  logic [exp3_pkg::DIV_DW:0]   trial;
  logic                        qbit;

  // shift in the next numerator bit and try a subtract
  assign shift = {rem_r, quo_r[exp3_pkg::DIV_NW-1]};
  assign trial = shift - {1'b0, den_r};
  assign qbit  = (shift >= {1'b0, den_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == exp3_pkg::DIV_CW'(exp3_pkg::DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= qbit ? trial[exp3_pkg::DIV_DW-1:0] : shift[exp3_pkg::DIV_DW-1:0];
      quo_r <= {quo_r[exp3_pkg::DIV_NW-2:0], qbit};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

@@ src/exp3_dp.sv @@
// ---------------------------------------------------------------------------
// Exp3 datapath
// Arm state, exponential weights, probabilities, updates and result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "exp3_bandit_arm_selector_assert.svh"
module exp3_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire exp3_pkg::cmd_t               cmd,
  output exp3_pkg::sts_t                    sts,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [16:0]                  cfg_wdata,
  input  wire logic                         in_req_type,
  input  wire logic [7:0]                   in_allowed_arms,
  input  wire logic [15:0]                  in_random_fraction,
  input  wire logic signed [15:0]           in_reward,
  input  wire logic [7:0]                   in_repeat_count,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output logic [2:0]                        out_chosen_arm,
  output logic [16:0]                       out_arm_probability,
  output logic                              out_fault,
  output logic signed [15:0]                out_aspiration_level,
  output logic signed [15:0]                out_arm_mean_reward
);

  localparam int NA = exp3_pkg::NUM_ARMS;
  localparam int AW = exp3_pkg::ARM_W;
  localparam int CW = exp3_pkg::CNT_W;
  localparam int NW = exp3_pkg::DIV_NW;
  localparam int DW = exp3_pkg::DIV_DW;

  // configuration
  logic [15:0] eta_r;
  logic [16:0] gamma_cfg_r;
  logic [15:0] lambda_r;
  logic [16:0] gamma;

  // request payload
  logic [7:0]         mask_r;
  logic [15:0]        draw_r;
  logic signed [15:0] rew_r;
  logic [7:0]         tau_r;

  // arm state
  logic signed [31:0] gain_r  [NA];
  logic [16:0]        prob_r  [NA];
  logic signed [15:0] mean_r  [NA];
  logic [31:0]        total_r [NA];
  logic [31:0]        ucnt_r  [NA];
  logic [AW-1:0]      last_r;
  logic signed [15:0] asp_r;

  // select scratch
  logic [AW-1:0]      idx_r;
  logic signed [48:0] xv_r [NA];
  logic [16:0]        w_r  [NA];
  logic signed [48:0] xmax_r;
  logic [CW-1:0]      count_r;
  logic [19:0]        sum_r;
  logic [19:0]        d_r;
  logic               big_r;
  logic [20:0]        e_r;
  logic [16:0]        v_r;
  logic [4:0]         n_r;
  logic               zero_r;
  logic [16:0]        share_r;
  logic [19:0]        cum_r;
  logic               found_r;
  logic [AW-1:0]      farm_r;

  // update scratch
  logic signed [33:0] asp_k_r;
  logic [7:0]         tau_cnt_r;
  logic               fault_r;
  logic signed [40:0] q_r;
  logic signed [49:0] gp_r;
  logic               tz_r;
  logic               msign_r;

  // result register
  logic               out_valid_r;
  logic [2:0]         out_arm_r;
  logic [16:0]        out_prob_r;
  logic               out_fault_r;
  logic signed [15:0] out_asp_r;
  logic signed [15:0] out_mean_r;

  // divider
  logic          div_start;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          div_busy;
  logic          div_done;
  logic [NW-1:0] div_quo;

  // combinational terms
  logic signed [31:0] gain_cur;
  logic [16:0]        prob_cur;
  logic signed [15:0] mean_cur;
  logic [31:0]        total_cur;
  logic               allowed_cur;
  logic signed [48:0] x_prod;
  logic signed [48:0] x_diff;
  logic [36:0]        e_prod;
  logic [16:0]        t0;
  logic [16:0]        t1;
  logic [16:0]        t_dlt;
  logic [23:0]        ip;
  logic [16:0]        w_new;
  logic [33:0]        pnum;
  logic [16:0]        prob_new;
  logic [19:0]        cum_new;
  logic [15:0]        rabs;
  logic signed [40:0] quo_s;
  logic signed [40:0] q_new;
  logic signed [50:0] gsum;
  logic signed [31:0] gain_new;
  logic signed [32:0] asp_m;
  logic signed [33:0] asp_sum;
  logic signed [33:0] asp_k;
  logic [32:0]        t_sum;
  logic [31:0]        t_new;
  logic signed [16:0] mdiff;
  logic signed [25:0] mprod;
  logic [25:0]        mabs;
  logic signed [40:0] mq;
  logic [16:0]        one_m_lambda;

  assign gamma = (gamma_cfg_r > exp3_pkg::Q_ONE) ? exp3_pkg::Q_ONE : gamma_cfg_r;

  // current arm reads
  assign gain_cur    = gain_r[idx_r];
  assign prob_cur    = prob_r[idx_r];
  assign mean_cur    = mean_r[idx_r];
  assign total_cur   = total_r[idx_r];
  assign allowed_cur = mask_r[idx_r];

  // eta times gain, and distance from the largest
  assign x_prod = $signed({1'b0, eta_r}) * gain_cur;
  assign x_diff = xmax_r - xv_r[idx_r];
  assign e_prod = d_r * exp3_pkg::LOG2E;

  // table lookup with linear interpolation
  assign t0    = exp3_pkg::pow2_tab({1'b0, e_r[15:12]});
  assign t1    = exp3_pkg::pow2_tab({1'b0, e_r[15:12]} + 5'd1);
  assign t_dlt = t0 - t1;
  assign ip    = t_dlt[11:0] * e_r[11:0];
  assign w_new = (zero_r || !allowed_cur) ? 17'd0 : (v_r >> n_r);

  // probability terms
  assign pnum     = (exp3_pkg::Q_ONE - gamma) * w_r[idx_r];
  assign prob_new = allowed_cur ? (div_quo[16:0] + share_r) : 17'd0;
  assign cum_new  = cum_r + {3'd0, prob_cur};

  // gain update
  assign rabs     = rew_r[15] ? 16'(-rew_r) : 16'(rew_r);
  assign quo_s    = $signed({1'b0, div_quo});
  assign q_new    = rew_r[15] ? -quo_s : quo_s;
  assign gsum     = 51'(gp_r) + 51'(gain_cur);
  assign gain_new = (gsum > 51'sd2147483647) ? 32'sh7fffffff :
                    (gsum < -51'sd2147483648) ? 32'sh80000000 : gsum[31:0];

  // aspiration smoothing
  assign one_m_lambda = exp3_pkg::Q_ONE - {1'b0, lambda_r};
  assign asp_k   = $signed({1'b0, one_m_lambda}) * rew_r;
  assign asp_m   = $signed({1'b0, lambda_r}) * asp_r;
  assign asp_sum = 34'(asp_m) + asp_k_r;

  // tau total and mean
  assign t_sum = {1'b0, total_cur} + {25'd0, tau_r};
  assign t_new = t_sum[32] ? 32'hffffffff : t_sum[31:0];
  assign mdiff = 17'(rew_r) - 17'(mean_cur);
  assign mprod = mdiff * $signed({1'b0, tau_r});
  assign mabs  = mprod[25] ? 26'(-mprod) : 26'(mprod);
  assign mq    = msign_r ? -quo_s : quo_s;

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (cmd.op)
      exp3_pkg::OP_SHARE: begin
        div_start = 1'b1;
        div_num   = NW'(gamma);
        div_den   = DW'(count_r);
      end
      exp3_pkg::OP_PDIV: begin
        div_start = 1'b1;
        div_num   = NW'(pnum);
        div_den   = DW'(sum_r);
      end
      exp3_pkg::OP_UPREP: begin
        div_start = (prob_cur != 17'd0);
        div_num   = {rabs, 24'd0};
        div_den   = DW'(prob_cur);
      end
      exp3_pkg::OP_TOT: begin
        div_start = (t_new != 32'd0);
        div_num   = NW'(mabs);
        div_den   = t_new;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  exp3_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // configuration, arm state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eta_r       <= '0;
      gamma_cfg_r <= exp3_pkg::Q_ONE;
      lambda_r    <= '0;
      for (int i = 0; i < NA; i++) begin
        gain_r[i]  <= '0;
        prob_r[i]  <= '0;
        mean_r[i]  <= '0;
        total_r[i] <= '0;
        ucnt_r[i]  <= '0;
      end
      last_r      <= '0;
      asp_r       <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == exp3_pkg::CFG_ETA)    eta_r       <= cfg_wdata[15:0];
        if (cfg_index == exp3_pkg::CFG_GAMMA)  gamma_cfg_r <= cfg_wdata;
        if (cfg_index == exp3_pkg::CFG_LAMBDA) lambda_r    <= cfg_wdata[15:0];
      end

      // advance the arm index
      unique case (cmd.idx_step)
        exp3_pkg::IDX_INC: idx_r <= idx_r + 1'b1;
        exp3_pkg::IDX_CLR: idx_r <= '0;
        default:           idx_r <= idx_r;
      endcase

      // drop the result once taken
      if (!out_stall) out_valid_r <= 1'b0;

      unique case (cmd.op)
        exp3_pkg::OP_LOAD: begin
          idx_r   <= in_req_type ? last_r : '0;
          found_r <= 1'b0;
        end
        exp3_pkg::OP_PGET: prob_r[idx_r] <= prob_new;
        exp3_pkg::OP_CUM: begin
          if (!found_r && ({4'd0, draw_r} < cum_new)) found_r <= 1'b1;
        end
        exp3_pkg::OP_SELFIX: begin
          idx_r <= found_r ? farm_r : '0;
          if (found_r) last_r <= farm_r;
        end
        exp3_pkg::OP_GADD: gain_r[idx_r] <= gain_new;
        exp3_pkg::OP_ASP:  asp_r <= asp_sum[31:16];
        exp3_pkg::OP_TOT:  total_r[idx_r] <= t_new;
        exp3_pkg::OP_MGET: begin
          if (!tz_r) mean_r[idx_r] <= mean_cur + $signed(mq[15:0]);
          ucnt_r[idx_r] <= ucnt_r[idx_r] + 32'd1;
        end
        exp3_pkg::OP_SELOUT, exp3_pkg::OP_UOUT: out_valid_r <= 1'b1;
        default: begin
          found_r <= found_r;
        end
      endcase
    end
  end

  // scratch and result payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      exp3_pkg::OP_LOAD: begin
        mask_r  <= in_allowed_arms;
        draw_r  <= in_random_fraction;
        rew_r   <= in_reward;
        tau_r   <= in_repeat_count;
        count_r <= '0;
        sum_r   <= '0;
        cum_r   <= '0;
        xmax_r  <= '0;
      end
      exp3_pkg::OP_MULX: xv_r[idx_r] <= x_prod;
      exp3_pkg::OP_MAX: begin
        if (allowed_cur) begin
          if (count_r == '0 || xv_r[idx_r] > xmax_r) xmax_r <= xv_r[idx_r];
          count_r <= count_r + 1'b1;
        end
      end
      exp3_pkg::OP_DIFF: begin
        d_r   <= x_diff[35:16];
        big_r <= |x_diff[48:36];
      end
      exp3_pkg::OP_LOG: e_r <= e_prod[36:16];
      exp3_pkg::OP_INTERP: begin
        v_r    <= t0 - {5'd0, ip[23:12]};
        n_r    <= e_r[20:16];
        zero_r <= big_r || (e_r[20:16] >= 5'd17);
      end
      exp3_pkg::OP_WACC: begin
        w_r[idx_r] <= w_new;
        sum_r      <= sum_r + {3'd0, w_new};
      end
      exp3_pkg::OP_SHGET: share_r <= div_quo[16:0];
      exp3_pkg::OP_CUM: begin
        cum_r <= cum_new;
        if (!found_r && ({4'd0, draw_r} < cum_new)) farm_r <= idx_r;
      end
      exp3_pkg::OP_SELOUT: begin
        out_arm_r   <= found_r ? idx_r : '0;
        out_prob_r  <= found_r ? prob_cur : 17'd0;
        out_fault_r <= !found_r;
        out_asp_r   <= asp_r;
        out_mean_r  <= found_r ? mean_cur : 16'sd0;
      end
      exp3_pkg::OP_UPREP: begin
        asp_k_r   <= asp_k;
        tau_cnt_r <= tau_r;
        fault_r   <= (prob_cur == 17'd0);
      end
      exp3_pkg::OP_QGET: q_r  <= q_new;
      exp3_pkg::OP_GMUL: gp_r <= q_r * $signed({1'b0, tau_r});
      exp3_pkg::OP_ASP:  tau_cnt_r <= tau_cnt_r - 8'd1;
      exp3_pkg::OP_TOT: begin
        tz_r    <= (t_new == 32'd0);
        msign_r <= mprod[25];
      end
      exp3_pkg::OP_UOUT: begin
        out_arm_r   <= idx_r;
        out_prob_r  <= prob_cur;
        out_fault_r <= fault_r;
        out_asp_r   <= asp_r;
        out_mean_r  <= mean_cur;
      end
      default: begin
        cum_r <= cum_r;
      end
    endcase
  end

  // status towards the controller
  assign sts.idx_last    = (idx_r == AW'(NA - 1));
  assign sts.div_done    = div_done;
  assign sts.count_zero  = (count_r == '0);
  assign sts.allowed_cur = allowed_cur;
  assign sts.prob_zero   = (prob_cur == 17'd0);
  assign sts.tau_zero    = (tau_cnt_r == 8'd0);
  assign sts.tot_zero    = tz_r;
  assign sts.out_free    = !out_valid_r || !out_stall;

  assign out_valid            = out_valid_r;
  assign out_chosen_arm       = out_arm_r;
  assign out_arm_probability  = out_prob_r;
  assign out_fault            = out_fault_r;
  assign out_aspiration_level = out_asp_r;
  assign out_arm_mean_reward  = out_mean_r;

  // a division never starts on top of another
  `EXP3_ASSERT_IMPLY(a_div_idle, clk, rst_n, div_start, !div_busy)
  // once an arm is found, the draw always lies below the running sum
  `EXP3_ASSERT_IMPLY(a_found_cum, clk, rst_n, found_r, 20'(draw_r) < cum_r)
  // a result load always presents a result next cycle
  `EXP3_ASSERT_NEXT(a_out_load, clk, rst_n,
                    cmd.op == exp3_pkg::OP_SELOUT || cmd.op == exp3_pkg::OP_UOUT,
                    out_valid_r)

endmodule
`default_nettype wire

@@ src/exp3_ctrl.sv @@
// ---------------------------------------------------------------------------
// Exp3 controller
// Sequences the select and update requests over the datapath.
// ---------------------------------------------------------------------------
`default_nettype none
module exp3_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_req_type,
  output logic                in_stall,
  input  wire exp3_pkg::sts_t sts,
  output exp3_pkg::cmd_t      cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MULX   = 5'd1;
  localparam logic [4:0] S_MAX    = 5'd2;
  localparam logic [4:0] S_DIFF   = 5'd3;
  localparam logic [4:0] S_LOG    = 5'd4;
  localparam logic [4:0] S_INTERP = 5'd5;
  localparam logic [4:0] S_WACC   = 5'd6;
  localparam logic [4:0] S_SHARE  = 5'd7;
  localparam logic [4:0] S_SHWAIT = 5'd8;
  localparam logic [4:0] S_PSTART = 5'd9;
  localparam logic [4:0] S_PWAIT  = 5'd10;
  localparam logic [4:0] S_CUM    = 5'd11;
  localparam logic [4:0] S_SELFIX = 5'd12;
  localparam logic [4:0] S_SELOUT = 5'd13;
  localparam logic [4:0] S_UPREP  = 5'd14;
  localparam logic [4:0] S_GWAIT  = 5'd15;
  localparam logic [4:0] S_GMUL   = 5'd16;
  localparam logic [4:0] S_GADD   = 5'd17;
  localparam logic [4:0] S_ASP    = 5'd18;
  localparam logic [4:0] S_TOT    = 5'd19;
  localparam logic [4:0] S_MWAIT  = 5'd20;
  localparam logic [4:0] S_UOUT   = 5'd21;

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and datapath command
  always_comb begin
    state_nxt    = state_r;
    cmd.op       = exp3_pkg::OP_NONE;
    cmd.idx_step = exp3_pkg::IDX_KEEP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = exp3_pkg::OP_LOAD;
          state_nxt = in_req_type ? S_UPREP : S_MULX;
        end
      end
      S_MULX: begin
        cmd.op       = exp3_pkg::OP_MULX;
        cmd.idx_step = sts.idx_last ? exp3_pkg::IDX_CLR : exp3_pkg::IDX_INC;
        if (sts.idx_last) state_nxt = S_MAX;
      end
      S_MAX: begin
        cmd.op       = exp3_pkg::OP_MAX;
        cmd.idx_step = sts.idx_last ? exp3_pkg::IDX_CLR : exp3_pkg::IDX_INC;
        if (sts.idx_last) state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.op    = exp3_pkg::OP_DIFF;
        state_nxt = S_LOG;
      end
      S_LOG: begin
        cmd.op    = exp3_pkg::OP_LOG;
        state_nxt = S_INTERP;
      end
      S_INTERP: begin
        cmd.op    = exp3_pkg::OP_INTERP;
        state_nxt = S_WACC;
      end
      S_WACC: begin
        cmd.op       = exp3_pkg::OP_WACC;
        cmd.idx_step = sts.idx_last ? exp3_pkg::IDX_CLR : exp3_pkg::IDX_INC;
        if (!sts.idx_last)       state_nxt = S_DIFF;
        else if (sts.count_zero) state_nxt = S_PSTART;
        else                     state_nxt = S_SHARE;
      end
      S_SHARE: begin
        cmd.op    = exp3_pkg::OP_SHARE;
        state_nxt = S_SHWAIT;
      end
      S_SHWAIT: begin
        if (sts.div_done) begin
          cmd.op    = exp3_pkg::OP_SHGET;
          state_nxt = S_PSTART;
        end
      end
      S_PSTART: begin
        if (sts.allowed_cur) begin
          cmd.op    = exp3_pkg::OP_PDIV;
          state_nxt = S_PWAIT;
        end else begin
          cmd.op    = exp3_pkg::OP_PGET;
          state_nxt = S_CUM;
        end
      end
      S_PWAIT: begin
        if (sts.div_done) begin
          cmd.op    = exp3_pkg::OP_PGET;
          state_nxt = S_CUM;
        end
      end
      S_CUM: begin
        cmd.op       = exp3_pkg::OP_CUM;
        cmd.idx_step = sts.idx_last ? exp3_pkg::IDX_CLR : exp3_pkg::IDX_INC;
        state_nxt    = sts.idx_last ? S_SELFIX : S_PSTART;
      end
      S_SELFIX: begin
        cmd.op    = exp3_pkg::OP_SELFIX;
        state_nxt = S_SELOUT;
      end
      S_SELOUT: begin
        if (sts.out_free) begin
          cmd.op    = exp3_pkg::OP_SELOUT;
          state_nxt = S_IDLE;
        end
      end
      S_UPREP: begin
        cmd.op    = exp3_pkg::OP_UPREP;
        state_nxt = sts.prob_zero ? S_ASP : S_GWAIT;
      end
      S_GWAIT: begin
        if (sts.div_done) begin
          cmd.op    = exp3_pkg::OP_QGET;
          state_nxt = S_GMUL;
        end
      end
      S_GMUL: begin
        cmd.op    = exp3_pkg::OP_GMUL;
        state_nxt = S_GADD;
      end
      S_GADD: begin
        cmd.op    = exp3_pkg::OP_GADD;
        state_nxt = S_ASP;
      end
      S_ASP: begin
        if (sts.tau_zero) state_nxt = S_TOT;
        else              cmd.op    = exp3_pkg::OP_ASP;
      end
      S_TOT: begin
        cmd.op    = exp3_pkg::OP_TOT;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts.tot_zero || sts.div_done) begin
          cmd.op    = exp3_pkg::OP_MGET;
          state_nxt = S_UOUT;
        end
      end
      S_UOUT: begin
        if (sts.out_free) begin
          cmd.op    = exp3_pkg::OP_UOUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

@@ src/exp3_bandit_arm_selector.sv @@
// A select and an update share one 40-step serial divider for their divides; an
//   update skips a divide when the probability or the new total is zero.
// Throughput: one request at a time; the next is taken while the result waits.
// Reset (synchronous, active low) clears gains, probabilities, means, totals,
//   counts, aspiration and the last arm, and loads the register defaults.
// ---------------------------------------------------------------------------
// Exp3 arm selector
// Adversarial bandit arm chooser with reward updates, fixed point.
// ---------------------------------------------------------------------------
`default_nettype none
module exp3_bandit_arm_selector (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_req_type,
  input  wire logic [7:0]         in_allowed_arms,
  input  wire logic [15:0]        in_random_fraction,
  input  wire logic signed [15:0] in_reward,
  input  wire logic [7:0]         in_repeat_count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_chosen_arm,
  output logic [16:0]             out_arm_probability,
  output logic                    out_fault,
  output logic signed [15:0]      out_aspiration_level,
  output logic signed [15:0]      out_arm_mean_reward,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [16:0]        cfg_wdata
);

  exp3_pkg::cmd_t cmd;
  exp3_pkg::sts_t sts;

  // sequencer
  exp3_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // arithmetic and state
  exp3_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_req_type          (in_req_type),
    .in_allowed_arms      (in_allowed_arms),
    .in_random_fraction   (in_random_fraction),
    .in_reward            (in_reward),
    .in_repeat_count      (in_repeat_count),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_chosen_arm       (out_chosen_arm),
    .out_arm_probability  (out_arm_probability),
    .out_fault            (out_fault),
    .out_aspiration_level (out_aspiration_level),
    .out_arm_mean_reward  (out_arm_mean_reward)
  );

endmodule
`default_nettype wire

@@ bench/exp3_bandit_arm_selector_tb.sv @@
// ---------------------------------------------------------------------------
// Exp3 arm selector testbench
// Drives select and reward-update requests through the valid/stall channels.
// Every accepted request is predicted by a bit-accurate model of the
// selector, and each result is compared field by field, in order. A directed
// table opens the run. Random request pairs follow under four register
// settings, with random idling on both sides, a long receiver hold-off and
// a full drain pause.
// ---------------------------------------------------------------------------
`default_nettype none
module exp3_bandit_arm_selector_tb;

  typedef struct {
    logic               req_type;
    logic [7:0]         allowed;
    logic [15:0]        draw;
    logic signed [15:0] reward;
    logic [7:0]         tau;
  } arm_req_t;

  typedef struct {
    logic [2:0]  arm;
    logic [16:0] prob;
    logic        fault;
    logic [15:0] asp;
    logic [15:0] mean;
  } arm_res_t;

  typedef struct {
    arm_req_t req;
    bit       typed;
    arm_res_t res;
  } dir_row_t;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int REQ_SELECT  = 0;
  localparam int REQ_UPDATE  = 1;

  localparam logic [16:0] EXP2_TAB [17] = '{
    65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
    44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_req_type = 1'b0;
  logic [7:0]         in_allowed_arms = '0;
  logic [15:0]        in_random_fraction = '0;
  logic signed [15:0] in_reward = '0;
  logic [7:0]         in_repeat_count = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_chosen_arm;
  logic [16:0]        out_arm_probability;
  logic               out_fault;
  logic signed [15:0] out_aspiration_level;
  logic signed [15:0] out_arm_mean_reward;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [16:0]        cfg_wdata = '0;

  // model state
  int          eta_q;
  int          gamma_q;
  int          lambda_q;
  int          gain_q [exp3_pkg::NUM_ARMS];
  int unsigned prob_q [exp3_pkg::NUM_ARMS];
  int          mean_q [exp3_pkg::NUM_ARMS];
  int unsigned tau_total_q [exp3_pkg::NUM_ARMS];
  int unsigned upd_count_q [exp3_pkg::NUM_ARMS];
  int          last_arm_q;
  int          asp_q;

  arm_res_t pending_results[$];
  arm_res_t typed_results[$];
  bit       typed_flags[$];
  int       fail_count = 0;
  int       send_idle = 0;
  int       rcv_idle = 0;
  int       hold_req = 0;
  int       cycle_count = 0;

  exp3_bandit_arm_selector uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // give up on a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("exp3_bandit_arm_selector: mismatch");
      $finish;
    end
  end

  // receiver: random stall plus long hold-offs counted here
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_req  <= hold_req - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  function automatic longint unsigned exp2_neg(longint unsigned d);
    longint unsigned n, frac, j, lo, v;
    n    = d >> 16;
    frac = d & 64'hFFFF;
    j    = frac >> 12;
    lo   = frac & 64'hFFF;
    if (n >= 17) return 0;
    v = EXP2_TAB[j] - (((EXP2_TAB[j] - EXP2_TAB[j + 1]) * lo) >> 12);
    return v >> n;
  endfunction

  // advance the selector state by one request, return its result
  function automatic arm_res_t exp3_predict(arm_req_t r);
    arm_res_t        res;
    longint          x, xmax, q, g, v, diff, rw;
    longint unsigned d, t, sum, cum, gam, tau;
    longint unsigned w [exp3_pkg::NUM_ARMS];
    int              cnt, arm, mean_out;
    bit              any, found, fault;
    rw = r.reward;
    tau = r.tau;
    arm = 0; fault = 0; mean_out = 0;
    res.prob = '0;
    if (r.req_type == REQ_SELECT) begin
      gam = (gamma_q > 65536) ? 65536 : gamma_q;
      any = 0; cnt = 0; xmax = 0; sum = 0; cum = 0; found = 0;
      for (int i = 0; i < exp3_pkg::NUM_ARMS; i++) begin
        if (r.allowed[i]) begin
          x = longint'(eta_q) * longint'(gain_q[i]);
          if (!any || x > xmax) xmax = x;
          any = 1;
          cnt++;
        end
      end
      for (int i = 0; i < exp3_pkg::NUM_ARMS; i++) begin
        w[i] = 0;
        if (r.allowed[i]) begin
          x = longint'(eta_q) * longint'(gain_q[i]);
          d = longint'(xmax - x) >> 16;
          w[i] = exp2_neg((d * 94548) >> 16);
          sum += w[i];
        end
      end
      for (int i = 0; i < exp3_pkg::NUM_ARMS; i++) begin
        if (w[i] != 0 || r.allowed[i])
          prob_q[i] = ((65536 - gam) * w[i]) / sum + gam / cnt;
        else
          prob_q[i] = 0;
      end
      for (int i = 0; i < exp3_pkg::NUM_ARMS && !found; i++) begin
        cum += prob_q[i];
        if (r.draw < cum) begin
          found = 1;
          arm = i;
        end
      end
      if (found) begin
        last_arm_q = arm;
        res.prob   = prob_q[arm];
        mean_out   = mean_q[arm];
      end else begin
        arm = 0;
        fault = 1;
      end
    end else begin
      arm = last_arm_q;
      res.prob = prob_q[arm];
      if (prob_q[arm] == 0) begin
        fault = 1;
      end else begin
        q = (rw * 16777216) / longint'(prob_q[arm]);
        g = longint'(gain_q[arm]) + q * longint'(tau);
        if (g > 64'sd2147483647) g = 64'sd2147483647;
        if (g < -64'sd2147483648) g = -64'sd2147483648;
        gain_q[arm] = int'(g);
      end
      for (int k = 0; k < tau; k++) begin
        v = longint'(lambda_q) * asp_q + longint'(65536 - lambda_q) * rw;
        asp_q = int'(v >>> 16);
      end
      t = longint'(tau_total_q[arm]) + tau;
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      tau_total_q[arm] = t;
      if (t != 0) begin
        diff = rw - mean_q[arm];
        mean_q[arm] += int'((diff * longint'(tau)) / longint'(t));
      end
      upd_count_q[arm] += 1;
      mean_out = mean_q[arm];
    end
    res.arm   = arm;
    res.fault = fault;
    res.asp   = asp_q[15:0];
    res.mean  = mean_out[15:0];
    return res;
  endfunction

  // predict every accepted request
  always @(posedge clk) begin
    arm_res_t pr;
    if (rst_n && in_valid && !in_stall) begin
      pr = exp3_predict('{in_req_type, in_allowed_arms, in_random_fraction,
                          in_reward, in_repeat_count});
      if (typed_flags.size() > 0 && typed_flags.pop_front())
        pr = typed_results.pop_front();
      pending_results.push_back(pr);
    end
  end

  // check every accepted result against the oldest expectation
  always @(posedge clk) begin
    arm_res_t ex;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: arm %0d", out_chosen_arm);
        fail_count++;
      end else begin
        ex = pending_results.pop_front();
        if (out_chosen_arm !== ex.arm) begin
          $error("chosen_arm: expected %0d, got %0d", ex.arm, out_chosen_arm);
          fail_count++;
        end
        if (out_arm_probability !== ex.prob) begin
          $error("arm_probability: expected %0d, got %0d", ex.prob, out_arm_probability);
          fail_count++;
        end
        if (out_fault !== ex.fault) begin
          $error("fault: expected %0d, got %0d", ex.fault, out_fault);
          fail_count++;
        end
        if (out_aspiration_level !== ex.asp) begin
          $error("aspiration_level: expected %0d, got %0d",
                 $signed(ex.asp), out_aspiration_level);
          fail_count++;
        end
        if (out_arm_mean_reward !== ex.mean) begin
          $error("arm_mean_reward: expected %0d, got %0d",
                 $signed(ex.mean), out_arm_mean_reward);
          fail_count++;
        end
      end
    end
  end

  // offer one request, hold it until taken
  task automatic send_req(arm_req_t r);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_req_type        <= r.req_type;
    in_allowed_arms    <= r.allowed;
    in_random_fraction <= r.draw;
    in_reward          <= r.reward;
    in_repeat_count    <= r.tau;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid and wait for every expected result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all three registers while idle
  task automatic set_regs(int eta, int gam, int lam);
    cfg_we <= 1'b1; cfg_index <= exp3_pkg::CFG_ETA; cfg_wdata <= eta;
    @(posedge clk);
    cfg_index <= exp3_pkg::CFG_GAMMA; cfg_wdata <= gam;
    @(posedge clk);
    cfg_index <= exp3_pkg::CFG_LAMBDA; cfg_wdata <= lam;
    @(posedge clk);
    cfg_we <= 1'b0;
    eta_q = eta & 16'hFFFF;
    gamma_q = gam & 17'h1FFFF;
    lambda_q = lam & 16'hFFFF;
    @(posedge clk);
  endtask

  function automatic arm_req_t rand_req(bit upd);
    arm_req_t r;
    int       m;
    r.req_type = upd;
    m = $urandom_range(9);
    r.allowed = (m == 0) ? 8'h00 : (m == 1) ? 8'hFF : $urandom_range(255);
    r.draw = ($urandom_range(9) == 0) ? 16'hFFFF : $urandom_range(65535);
    r.reward = $urandom_range(65535);
    m = $urandom_range(19);
    r.tau = (m == 0) ? 8'hFF : (m < 4) ? $urandom_range(255) : $urandom_range(0, 12);
    return r;
  endfunction

  // mostly select/update pairs, some lone random requests
  task automatic random_phase(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 75) begin
        send_req(rand_req(REQ_SELECT));
        send_req(rand_req(REQ_UPDATE));
        sent += 2;
      end else begin
        send_req(rand_req($urandom_range(1)));
        sent++;
      end
    end
  endtask

  dir_row_t dir_tab [14] = '{
    '{'{0, 8'h00, 16'h0000, 16'sd0, 8'd0},      1, '{0, 0, 1, 0, 0}},
    '{'{0, 8'h07, 16'hFFFF, 16'sd0, 8'd0},      1, '{0, 0, 1, 0, 0}},
    '{'{1, 8'h00, 16'h0000, 16'sd100, 8'd1},    1, '{0, 21845, 0, 100, 100}},
    '{'{0, 8'hFF, 16'h0000, 16'sd0, 8'd0},      1, '{0, 8192, 0, 100, 100}},
    '{'{0, 8'hFF, 16'hFFFF, 16'sd0, 8'd0},      1, '{7, 8192, 0, 100, 0}},
    '{'{1, 8'h00, 16'h0000, 16'sd32767, 8'd0},  1, '{7, 8192, 0, 100, 0}},
    '{'{1, 8'hFF, 16'hFFFF, -16'sd32768, 8'd255}, 0, '{0, 0, 0, 0, 0}},
    '{'{0, 8'h80, 16'hFFFF, 16'sd0, 8'd0},      0, '{0, 0, 0, 0, 0}},
    '{'{1, 8'h55, 16'h5555, 16'sh5555, 8'hAA},  0, '{0, 0, 0, 0, 0}},
    '{'{0, 8'h01, 16'h0000, 16'sh2AAA, 8'h55},  0, '{0, 0, 0, 0, 0}},
    '{'{1, 8'hAA, 16'hAAAA, 16'shAAAA, 8'h55},  0, '{0, 0, 0, 0, 0}},
    '{'{0, 8'h55, 16'h8000, 16'sd32767, 8'd255}, 0, '{0, 0, 0, 0, 0}},
    '{'{1, 8'h00, 16'h0000, 16'sd32767, 8'd255}, 0, '{0, 0, 0, 0, 0}},
    '{'{0, 8'hAA, 16'h7FFF, -16'sd1, 8'd1},     0, '{0, 0, 0, 0, 0}}
  };

  initial begin
    eta_q = 0; gamma_q = 65536; lambda_q = 0;
    last_arm_q = 0; asp_q = 0;
    for (int i = 0; i < exp3_pkg::NUM_ARMS; i++) begin
      gain_q[i] = 0; prob_q[i] = 0; mean_q[i] = 0;
      tau_total_q[i] = 0; upd_count_q[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table under reset registers
    for (int i = 0; i < 14; i++) begin
      typed_flags.push_back(dir_tab[i].typed);
      if (dir_tab[i].typed) typed_results.push_back(dir_tab[i].res);
      send_req(dir_tab[i].req);
    end
    drain();

    // sharp softmax, no exploration, slow aspiration
    set_regs(65535, 0, 65535);
    send_idle = 18; rcv_idle = 58;
    random_phase(135);
    drain();

    set_regs($urandom_range(0, 4096), $urandom_range(0, 65536), $urandom_range(65535));
    send_idle = 58; rcv_idle = 18;
    random_phase(135);
    drain();

    // oversize gamma acts as one
    set_regs(300, 131071, 0);
    send_idle = 0; rcv_idle = 0;
    hold_req = 3000;
    random_phase(30);
    drain();
    set_regs(2000, 6000, 40000);
    random_phase(100);
    drain();

    repeat (500) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("exp3_bandit_arm_selector: match");
    end else begin
      $display("exp3_bandit_arm_selector: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
